// ===== src/mahd_pkg.sv =====
package mahd_pkg;

  localparam int HdrW      = 32;
  localparam int AvailW    = 12;
  localparam int StatusW   = 3;
  localparam int LenW      = 12;
  localparam int BrW       = 19;
  localparam int SrW       = 16;
  localparam int LayW      = 2;
  localparam int VerW      = 2;
  localparam int DurW      = 18;
  localparam int Num1W     = 26;
  localparam int Num2W     = 35;
  localparam int InTdataW  = 48;
  localparam int OutTdataW = 72;

  localparam logic [10:0]  SyncWord   = 11'h7FF;
  localparam logic [22:0]  EightMega  = 23'd8000000;
  localparam logic [SrW-1:0] Sr44k1   = 16'd44100;
  localparam logic [SrW-1:0] Sr48k    = 16'd48000;
  localparam logic [SrW-1:0] Sr32k    = 16'd32000;

  typedef enum logic [StatusW-1:0] {
    ST_OK          = 3'd0,
    ST_NO_SYNC     = 3'd1,
    ST_RESERVED    = 3'd2,
    ST_BAD_BITRATE = 3'd3,
    ST_TOO_SHORT   = 3'd4
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [BrW-1:0]      br;
    logic [SrW-1:0]      sr;
    logic [LayW-1:0]     lay;
    logic [VerW-1:0]     ver;
    logic                pad;
    logic [AvailW-1:0]   avail;
  } info_t;

  typedef struct packed {
    info_t               info;
    logic [LenW-1:0]     len;
  } mid_t;

  localparam logic [BrW-1:0] RateTab [16][6] = '{
    '{19'd0,      19'd0,      19'd0,      19'd0,      19'd0,      19'd0},
    '{19'd32000,  19'd32000,  19'd32000,  19'd32000,  19'd8000,   19'd8000},
    '{19'd64000,  19'd48000,  19'd40000,  19'd48000,  19'd16000,  19'd16000},
    '{19'd96000,  19'd56000,  19'd48000,  19'd56000,  19'd24000,  19'd24000},
    '{19'd128000, 19'd64000,  19'd56000,  19'd64000,  19'd32000,  19'd32000},
    '{19'd160000, 19'd80000,  19'd64000,  19'd80000,  19'd40000,  19'd40000},
    '{19'd192000, 19'd96000,  19'd80000,  19'd96000,  19'd48000,  19'd48000},
    '{19'd224000, 19'd112000, 19'd96000,  19'd112000, 19'd56000,  19'd56000},
    '{19'd256000, 19'd128000, 19'd112000, 19'd128000, 19'd64000,  19'd64000},
    '{19'd288000, 19'd160000, 19'd128000, 19'd144000, 19'd80000,  19'd80000},
    '{19'd320000, 19'd192000, 19'd160000, 19'd160000, 19'd96000,  19'd96000},
    '{19'd352000, 19'd224000, 19'd192000, 19'd176000, 19'd112000, 19'd112000},
    '{19'd384000, 19'd256000, 19'd224000, 19'd192000, 19'd128000, 19'd128000},
    '{19'd416000, 19'd320000, 19'd256000, 19'd224000, 19'd144000, 19'd144000},
    '{19'd448000, 19'd384000, 19'd320000, 19'd256000, 19'd160000, 19'd160000},
    '{19'd0,      19'd0,      19'd0,      19'd0,      19'd0,      19'd0}
  };

endpackage

// ===== src/mpeg_audio_header_decode.sv =====
// Decodes one MPEG audio frame header per input word.
// The input stream carries the 32-bit header, first stream byte in the top
// bits, and the count of bytes available from the header start. Each word
// accepted gives exactly one result word: status, frame length, bitrate,
// sample rate, layer, version and frame duration in microseconds.
// The header is checked and decoded in one stage; the frame length then
// comes out of a row of 26 restoring division cells, one quotient bit each,
// a further stage checks the length against the bytes available, and the
// duration comes out of a second row of 35 division cells.
// Throughput is one header per cycle while the receiver keeps taking results;
// each cell holds at most one word in flight.
// A cell moves its word on whenever the next cell is empty or moving, so a
// stalled receiver fills the row from the output end and in_tready falls
// only once every stage holds a word; gaps in the row close up during a stall.
// Reset empties every cell; no word is in flight afterwards.
module mpeg_audio_header_decode (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // header_word [31:0], bytes_available [43:32], zero [47:44]
  input  logic [mahd_pkg::InTdataW-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status [2:0], frame_length [14:3], bitrate_bps [33:15],
  // sample_rate_hz [49:34], layer_number [51:50], version_number [53:52],
  // duration_us [71:54]
  output logic [mahd_pkg::OutTdataW-1:0]   out_tdata
);
  import mahd_pkg::*;

  logic             dec_valid, dec_ready;
  info_t            dec_info;
  logic [Num1W-1:0] dec_num;
  logic [SrW-1:0]   dec_dvs;
  logic             d1_valid, d1_ready;
  logic [LenW-1:0]  d1_quot;
  info_t            d1_info;
  logic             len_valid, len_ready;
  mid_t             len_mid;
  logic [Num2W-1:0] len_num;
  logic [BrW-1:0]   len_dvs;
  logic [DurW-1:0]  d2_quot;
  mid_t             d2_mid;
  logic [DurW-1:0]  dur;

  mahd_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .header_word    (in_tdata[31:0]),
    .bytes_available(in_tdata[43:32]),
    .out_valid      (dec_valid),
    .out_ready      (dec_ready),
    .info           (dec_info),
    .num            (dec_num),
    .dvs            (dec_dvs)
  );

  mahd_divider #(.NW(Num1W), .DW(SrW), .QW(LenW), .PW($bits(info_t))) u_len_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (dec_valid),
    .in_ready (dec_ready),
    .num_in   (dec_num),
    .div_in   (dec_dvs),
    .pay_in   (dec_info),
    .out_valid(d1_valid),
    .out_ready(d1_ready),
    .quot_out (d1_quot),
    .pay_out  (d1_info)
  );

  mahd_len u_len (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (d1_valid),
    .in_ready (d1_ready),
    .info     (d1_info),
    .quot     (d1_quot),
    .out_valid(len_valid),
    .out_ready(len_ready),
    .mid      (len_mid),
    .num      (len_num),
    .dvs      (len_dvs)
  );

  mahd_divider #(.NW(Num2W), .DW(BrW), .QW(DurW), .PW($bits(mid_t))) u_dur_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (len_valid),
    .in_ready (len_ready),
    .num_in   (len_num),
    .div_in   (len_dvs),
    .pay_in   (len_mid),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .quot_out (d2_quot),
    .pay_out  (d2_mid)
  );

  assign dur = (d2_mid.info.status == ST_OK) ? d2_quot : '0;

  assign out_tdata = {dur, d2_mid.info.ver, d2_mid.info.lay, d2_mid.info.sr,
                      d2_mid.info.br, d2_mid.len, d2_mid.info.status};

endmodule

// ===== src/mahd_div_cell.sv =====
module mahd_div_cell #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] rem_in,
  input  logic [NW-1:0] num_in,
  input  logic [QW-1:0] quot_in,
  input  logic [DW-1:0] div_in,
  input  logic [PW-1:0] pay_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] rem_out,
  output logic [NW-1:0] num_out,
  output logic [QW-1:0] quot_out,
  output logic [DW-1:0] div_out,
  output logic [PW-1:0] pay_out
);

  logic          valid_r;
  logic [DW-1:0] rem_r, rem_nxt, div_r;
  logic [NW-1:0] num_r, num_nxt;
  logic [QW-1:0] quot_r, quot_nxt;
  logic [PW-1:0] pay_r;
  logic [DW:0]   trial, diff;
  logic          take;

  always_comb begin
    trial    = {rem_in, num_in[NW-1]};
    diff     = trial - {1'b0, div_in};
    take     = trial >= {1'b0, div_in};
    rem_nxt  = take ? diff[DW-1:0] : trial[DW-1:0];
    num_nxt  = {num_in[NW-2:0], 1'b0};
    quot_nxt = {quot_in[QW-2:0], take};
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r  <= rem_nxt;
      num_r  <= num_nxt;
      quot_r <= quot_nxt;
      div_r  <= div_in;
      pay_r  <= pay_in;
    end
  end

  assign out_valid = valid_r;
  assign rem_out   = rem_r;
  assign num_out   = num_r;
  assign quot_out  = quot_r;
  assign div_out   = div_r;
  assign pay_out   = pay_r;

endmodule

// ===== src/mahd_divider.sv =====
module mahd_divider #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NW-1:0] num_in,
  input  logic [DW-1:0] div_in,
  input  logic [PW-1:0] pay_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] quot_out,
  output logic [PW-1:0] pay_out
);

  logic          vld  [NW+1];
  logic          rdy  [NW+1];
  logic [DW-1:0] rem  [NW+1];
  logic [NW-1:0] num  [NW+1];
  logic [QW-1:0] quot [NW+1];
  logic [DW-1:0] dvs  [NW+1];
  logic [PW-1:0] pay  [NW+1];

  assign vld[0]  = in_valid;
  assign in_ready = rdy[0];
  assign rem[0]  = '0;
  assign num[0]  = num_in;
  assign quot[0] = '0;
  assign dvs[0]  = div_in;
  assign pay[0]  = pay_in;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    mahd_div_cell #(.NW(NW), .DW(DW), .QW(QW), .PW(PW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (vld[i]),
      .in_ready (rdy[i]),
      .rem_in   (rem[i]),
      .num_in   (num[i]),
      .quot_in  (quot[i]),
      .div_in   (dvs[i]),
      .pay_in   (pay[i]),
      .out_valid(vld[i+1]),
      .out_ready(rdy[i+1]),
      .rem_out  (rem[i+1]),
      .num_out  (num[i+1]),
      .quot_out (quot[i+1]),
      .div_out  (dvs[i+1]),
      .pay_out  (pay[i+1])
    );
  end

  assign rdy[NW]   = out_ready;
  assign out_valid = vld[NW];
  assign quot_out  = quot[NW];
  assign pay_out   = pay[NW];

endmodule

// ===== src/mahd_decode.sv =====
module mahd_decode (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mahd_pkg::HdrW-1:0]      header_word,
  input  logic [mahd_pkg::AvailW-1:0]    bytes_available,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mahd_pkg::info_t                info,
  output logic [mahd_pkg::Num1W-1:0]     num,
  output logic [mahd_pkg::SrW-1:0]       dvs
);
  import mahd_pkg::*;

  logic             valid_r;
  info_t            info_r, info_nxt;
  logic [Num1W-1:0] num_r, num_nxt;
  logic [SrW-1:0]   dvs_r, dvs_nxt;
  logic [1:0]       vcode, lcode, scode;
  logic [3:0]       bidx;
  logic [2:0]       col;
  logic [7:0]       mult;
  logic [SrW-1:0]   sr_base;
  logic [BrW-1:0]   br;

  always_comb begin
    vcode = header_word[20:19];
    lcode = header_word[18:17];
    bidx  = header_word[15:12];
    scode = header_word[11:10];
    info_nxt = '0;
    info_nxt.pad   = header_word[9];
    info_nxt.avail = bytes_available;
    info_nxt.lay   = 2'(~lcode + 2'd1);
    case (scode)
      2'd0:    sr_base = Sr44k1;
      2'd1:    sr_base = Sr48k;
      default: sr_base = Sr32k;
    endcase
    case (vcode)
      2'd3: begin
        info_nxt.ver = 2'd1;
        info_nxt.sr  = sr_base;
      end
      2'd2: begin
        info_nxt.ver = 2'd2;
        info_nxt.sr  = sr_base >> 1;
      end
      default: begin
        info_nxt.ver = 2'd2;
        info_nxt.sr  = sr_base >> 2;
      end
    endcase
    col = 3'(info_nxt.lay - 2'd1) + ((info_nxt.ver == 2'd2) ? 3'd3 : 3'd0);
    br  = RateTab[bidx][col];
    if (info_nxt.lay == 2'd1) begin
      mult = 8'd12;
    end else if (info_nxt.lay == 2'd3 && info_nxt.ver == 2'd2) begin
      mult = 8'd72;
    end else begin
      mult = 8'd144;
    end
    info_nxt.br     = br;
    info_nxt.status = ST_OK;
    if (bytes_available < 12'd4 || header_word[31:21] != SyncWord ||
        vcode == 2'd1 || lcode == 2'd0 || scode == 2'd3) begin
      info_nxt.status = (bytes_available < 12'd4) ? ST_TOO_SHORT :
                        (header_word[31:21] != SyncWord) ? ST_NO_SYNC : ST_RESERVED;
      info_nxt.br  = '0;
      info_nxt.sr  = '0;
      info_nxt.lay = '0;
      info_nxt.ver = '0;
    end else if (br == '0) begin
      info_nxt.status = ST_BAD_BITRATE;
    end
    num_nxt = (info_nxt.status == ST_OK) ? Num1W'(mult * br) : '0;
    dvs_nxt = (info_nxt.sr == '0) ? SrW'(1) : info_nxt.sr;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      info_r <= info_nxt;
      num_r  <= num_nxt;
      dvs_r  <= dvs_nxt;
    end
  end

  assign out_valid = valid_r;
  assign info      = info_r;
  assign num       = num_r;
  assign dvs       = dvs_r;

endmodule

// ===== src/mahd_len.sv =====
module mahd_len (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mahd_pkg::info_t             info,
  input  logic [mahd_pkg::LenW-1:0]   quot,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mahd_pkg::mid_t              mid,
  output logic [mahd_pkg::Num2W-1:0]  num,
  output logic [mahd_pkg::BrW-1:0]    dvs
);
  import mahd_pkg::*;

  logic             valid_r;
  mid_t             mid_r, mid_nxt;
  logic [Num2W-1:0] num_r, num_nxt;
  logic [BrW-1:0]   dvs_r, dvs_nxt;
  logic [13:0]      slots, len_w;

  always_comb begin
    slots = {2'b00, quot} + {13'd0, info.pad};
    len_w = (info.lay == 2'd1) ? {slots[11:0], 2'b00} : slots;
    mid_nxt.info = info;
    mid_nxt.len  = '0;
    if (info.status == ST_OK) begin
      if ({2'b00, info.avail} < len_w + 14'd4) begin
        mid_nxt.info.status = ST_TOO_SHORT;
      end else begin
        mid_nxt.len = len_w[LenW-1:0];
      end
    end
    num_nxt = Num2W'(mid_nxt.len * EightMega);
    dvs_nxt = (info.br == '0) ? BrW'(1) : info.br;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mid_r <= mid_nxt;
      num_r <= num_nxt;
      dvs_r <= dvs_nxt;
    end
  end

  assign out_valid = valid_r;
  assign mid       = mid_r;
  assign num       = num_r;
  assign dvs       = dvs_r;

endmodule
